// ===== rtl/cno_pkg.sv =====
// Package for the contour normal offset block: types, widths, state codes.
// Used by every module under rtl but cno_checker; no dependencies of its own.
package cno_pkg;

  localparam int COORD_W   = 12;             // vertex coordinate width
  localparam int IDX_W     = 12;             // result index width
  localparam int OUT_W     = 14;             // moved coordinate width
  localparam int DIST_W    = 9;              // offset distance width
  localparam int MAX_VERTICES = 4096;
  localparam int CNT_W     = 13;             // holds 0..MAX_VERTICES
  localparam int CHORD_W   = COORD_W + 1;    // signed chord component
  localparam int SQ_W      = 2 * COORD_W;    // square of one component
  localparam int LEN_W     = SQ_W + 2;       // sum of two squares
  localparam int REM_W     = LEN_W + 2;      // divider remainder
  localparam int QUO_W     = 33;             // quotient of a^2*2^32/len2, at most 2^32
  localparam int DIV_STEPS = QUO_W;
  localparam int RAD_W     = QUO_W + 1;      // radicand padded to even width
  localparam int ROOT_W    = RAD_W / 2;      // 17 bits, root at most 2^16
  localparam int SREM_W    = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int NRM_W     = ROOT_W + 1;     // signed normal component, Q16
  localparam int PROD_W    = NRM_W + DIST_W;
  localparam int T_W       = 30;             // v*2^16 + d*n
  localparam int STEP_W    = 6;
  localparam int DIST_RESET = 30;
  localparam int REG_OFFSET_DISTANCE = 0;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pt_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    pt_t              pre;
    pt_t              now;
    pt_t              nxt;
    logic             eop;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SQUARE,
    S_DIV,
    S_SQRT,
    S_MUL,
    S_WRITE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       setup;
    logic       square;
    logic       div_first;
    logic       div_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       mul;
    logic       write;
    logic [1:0] job_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] njobs;     // results caused by the word at the input
    logic       zero;      // current chord is zero
    logic       out_busy;  // output register full and not being taken
  } status_t;

endpackage

// ===== rtl/cno_cfg.sv =====
// Configuration register file: APB-style write/read of offset_distance.
// Depends on cno_pkg.
module cno_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output logic signed [cno_pkg::DIST_W-1:0] offset_dist
);
  import cno_pkg::*;

  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              wr_en;
  logic              hit;

  // register index is paddr[2]; only index 0 exists
  assign hit   = (cfg_paddr[2] == 1'(REG_OFFSET_DISTANCE));
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit;
  assign dist_nxt = wr_en ? cfg_pwdata[DIST_W-1:0] : dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= DIST_W'(DIST_RESET);
    end else begin
      dist_r <= dist_nxt;
    end
  end

  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = hit ? {{(32-DIST_W){1'b0}}, dist_r} : 32'd0;
  assign offset_dist = signed'(dist_r);

endmodule

// ===== rtl/cno_ctrl.sv =====
// Controller: sequences each result through setup, square, divide, root,
// multiply and write; a zero chord skips from square to write. Depends on cno_pkg.
module cno_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cno_pkg::status_t  sts,
  output cno_pkg::cmd_t     cmd
);
  import cno_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]        job_r, job_nxt;
  logic [1:0]        njobs_r, njobs_nxt;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      job_r   <= '0;
      njobs_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      job_r   <= job_nxt;
      njobs_r <= njobs_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    job_nxt     = job_r;
    njobs_nxt   = njobs_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.job_sel = job_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          job_nxt    = '0;
          njobs_nxt  = sts.njobs;
          if (sts.njobs != 2'd0) begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = sts.zero ? S_WRITE : S_DIV;
      end
      S_DIV: begin
        cmd.div_first = (cnt_r == '0);
        cmd.div_step  = (cnt_r != '0);
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_init = (cnt_r == '0);
        cmd.sqrt_step = (cnt_r != '0);
        if (cnt_r == STEP_W'(SQRT_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!sts.out_busy) begin
          cmd.write = 1'b1;
          if (job_r == njobs_r - 2'd1) begin
            state_nxt = S_IDLE;
          end else begin
            job_nxt   = job_r + 2'd1;
            state_nxt = S_SETUP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/cno_dp.sv =====
// Datapath: polygon bookkeeping, job slots, two divide/root lanes, output
// register. Depends on cno_pkg.
module cno_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cno_pkg::cmd_t                      cmd,
  output cno_pkg::status_t                   sts,
  input  logic [cno_pkg::COORD_W-1:0]        vx,
  input  logic [cno_pkg::COORD_W-1:0]        vy,
  input  logic                               vlast,
  input  logic signed [cno_pkg::DIST_W-1:0]  offset_dist,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [cno_pkg::IDX_W-1:0]          out_idx,
  output logic [cno_pkg::OUT_W-1:0]          out_mx,
  output logic [cno_pkg::OUT_W-1:0]          out_my,
  output logic                               out_zero,
  output logic                               out_eop
);
  import cno_pkg::*;

  // polygon state
  pt_t              first_r, second_r, older_r, newer_r;
  logic [CNT_W-1:0] seen_r;
  job_t             jobs_r [3];
  job_t             job0, job1, job2;
  pt_t              cur;
  logic [1:0]       njobs;
  logic [IDX_W-1:0] cidx;

  // per-result registers
  job_t                      jcur;
  logic signed [CHORD_W-1:0] sx_r, sy_r;
  pt_t                       now_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      eop_r;
  logic [SQ_W-1:0]           a2_r [2];
  logic [LEN_W-1:0]          len2_r;
  logic [REM_W-1:0]          rem_r [2];
  logic [QUO_W-1:0]          quo_r [2];
  logic [RAD_W-1:0]          rad_r [2];
  logic [SREM_W-1:0]         srem_r [2];
  logic [ROOT_W-1:0]         root_r [2];
  logic signed [PROD_W-1:0]  prod_r [2];
  logic                      zero;

  // output register
  logic             ovalid_r;
  logic [IDX_W-1:0] oidx_r;
  logic [OUT_W-1:0] omx_r, omy_r;
  logic             ozero_r, oeop_r;

  assign cur = '{x: vx, y: vy};
  assign cidx = (seen_r < CNT_W'(MAX_VERTICES)) ? seen_r[IDX_W-1:0] : IDX_W'(MAX_VERTICES - 1);

  // results caused by the incoming vertex
  always_comb begin
    job0 = '0;
    job1 = '0;
    job2 = '0;
    njobs = 2'd0;
    if (seen_r == '0) begin
      job0 = '{idx: '0, pre: cur, now: cur, nxt: cur, eop: 1'b1};
      njobs = vlast ? 2'd1 : 2'd0;
    end else if (seen_r == CNT_W'(1)) begin
      job0 = '{idx: IDX_W'(1), pre: first_r, now: cur, nxt: first_r, eop: 1'b0};
      job1 = '{idx: '0, pre: cur, now: first_r, nxt: cur, eop: 1'b1};
      njobs = vlast ? 2'd2 : 2'd0;
    end else begin
      job0 = '{idx: IDX_W'(seen_r - 1'b1), pre: older_r, now: newer_r, nxt: cur, eop: 1'b0};
      job1 = '{idx: cidx, pre: newer_r, now: cur, nxt: first_r, eop: 1'b0};
      job2 = '{idx: '0, pre: cur, now: first_r, nxt: second_r, eop: 1'b1};
      njobs = vlast ? 2'd3 : 2'd1;
    end
  end

  // polygon bookkeeping on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
      older_r  <= '0;
      newer_r  <= '0;
      seen_r   <= '0;
    end else if (cmd.accept) begin
      if (vlast) begin
        first_r  <= '0;
        second_r <= '0;
        older_r  <= '0;
        newer_r  <= '0;
        seen_r   <= '0;
      end else begin
        if (seen_r == '0) begin
          first_r <= cur;
        end else if (seen_r == CNT_W'(1)) begin
          second_r <= cur;
          older_r  <= first_r;
          newer_r  <= cur;
        end else begin
          older_r <= newer_r;
          newer_r <= cur;
        end
        if (seen_r < CNT_W'(MAX_VERTICES)) begin
          seen_r <= seen_r + 1'b1;
        end
      end
    end
  end

  // job slots
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      jobs_r[0] <= job0;
      jobs_r[1] <= job1;
      jobs_r[2] <= job2;
    end
  end

  assign jcur = (cmd.job_sel == 2'd2) ? jobs_r[2] :
                (cmd.job_sel == 2'd1) ? jobs_r[1] : jobs_r[0];

  // chord of the selected result
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      sx_r  <= signed'({1'b0, jcur.nxt.x}) - signed'({1'b0, jcur.pre.x});
      sy_r  <= signed'({1'b0, jcur.nxt.y}) - signed'({1'b0, jcur.pre.y});
      now_r <= jcur.now;
      idx_r <= jcur.idx;
      eop_r <= jcur.eop;
    end
  end

  assign zero = (sx_r == '0) && (sy_r == '0);

  // squares: lane 0 (x result) uses sy, lane 1 (y result) uses sx
  logic [COORD_W-1:0] ax, ay;
  assign ay = sy_r[CHORD_W-1] ? COORD_W'(-sy_r) : COORD_W'(sy_r);
  assign ax = sx_r[CHORD_W-1] ? COORD_W'(-sx_r) : COORD_W'(sx_r);

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      a2_r[0] <= ay * ay;
      a2_r[1] <= ax * ax;
      len2_r  <= LEN_W'(ay * ay) + LEN_W'(ax * ax);
    end
  end

  // restoring divide and digit-by-digit root, one bit per cycle per lane
  logic [REM_W-1:0]    rem_sh  [2];
  logic                qbit    [2];
  logic [SREM_W+1:0]   srem_sh [2];
  logic [SREM_W+1:0]   trial   [2];
  logic                rbit    [2];
  logic signed [NRM_W-1:0] nrm [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l]  = cmd.div_first ? REM_W'(a2_r[l]) : {rem_r[l][REM_W-2:0], 1'b0};
      qbit[l]    = (rem_sh[l] >= REM_W'(len2_r));
      srem_sh[l] = {srem_r[l], rad_r[l][RAD_W-1 -: 2]};
      trial[l]   = (SREM_W+2)'({root_r[l], 2'b01});
      rbit[l]    = (srem_sh[l] >= trial[l]);
    end
    // x term follows sign of sy; y term is the negated normal of sx
    nrm[0] = sy_r[CHORD_W-1] ? -signed'({1'b0, root_r[0]}) : signed'({1'b0, root_r[0]});
    nrm[1] = sx_r[CHORD_W-1] ? signed'({1'b0, root_r[1]}) : -signed'({1'b0, root_r[1]});
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd.div_first || cmd.div_step) begin
        rem_r[l] <= qbit[l] ? rem_sh[l] - REM_W'(len2_r) : rem_sh[l];
        quo_r[l] <= {quo_r[l][QUO_W-2:0], qbit[l]};
      end
      if (cmd.sqrt_init) begin
        rad_r[l]  <= RAD_W'(quo_r[l]);
        srem_r[l] <= '0;
        root_r[l] <= '0;
      end else if (cmd.sqrt_step) begin
        rad_r[l]  <= {rad_r[l][RAD_W-3:0], 2'b00};
        srem_r[l] <= rbit[l] ? SREM_W'(srem_sh[l] - trial[l]) : SREM_W'(srem_sh[l]);
        root_r[l] <= {root_r[l][ROOT_W-2:0], rbit[l]};
      end
      if (cmd.mul) begin
        prod_r[l] <= PROD_W'(offset_dist * nrm[l]);
      end
    end
  end

  // v + d*n/2^16, truncated toward zero
  logic signed [T_W-1:0] tsum [2];
  logic signed [T_W-1:0] tadj [2];
  logic [OUT_W-1:0]      mv   [2];
  always_comb begin
    tsum[0] = signed'(T_W'({now_r.x, 16'd0})) + T_W'(prod_r[0]);
    tsum[1] = signed'(T_W'({now_r.y, 16'd0})) + T_W'(prod_r[1]);
    for (int l = 0; l < 2; l++) begin
      tadj[l] = tsum[l][T_W-1] ? tsum[l] + T_W'(65535) : tsum[l];
      mv[l]   = OUT_W'(tadj[l] >>> 16);
    end
  end

  // output register, loaded when empty or while its word is being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.write) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      oidx_r  <= idx_r;
      oeop_r  <= eop_r;
      ozero_r <= zero;
      omx_r   <= zero ? OUT_W'(now_r.x) : mv[0];
      omy_r   <= zero ? OUT_W'(now_r.y) : mv[1];
    end
  end

  assign sts.njobs    = njobs;
  assign sts.zero     = zero;
  assign sts.out_busy = ovalid_r && !out_ready;

  assign out_valid = ovalid_r;
  assign out_idx   = oidx_r;
  assign out_mx    = omx_r;
  assign out_my    = omy_r;
  assign out_zero  = ozero_r;
  assign out_eop   = oeop_r;

endmodule

// ===== rtl/contour_normal_offset_core.sv =====
// Each result word passes setup, square, divide, root, multiply and write in turn;
// a zero chord goes from square straight to write. A vertex word that causes no
// result is taken at once; otherwise the input stalls until every result word that
// the vertex causes has been written, output stalls included.
// Reset (rst_n low, synchronous) clears polygon state and output valid;
// offset_distance returns to 30. Top level; depends on cno_pkg, cno_cfg, cno_ctrl, cno_dp.
module contour_normal_offset_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // vertex_x[11:0], vertex_y[23:12]
  input  logic        in_tlast,   // is_last_vertex
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // vertex_index[11:0], moved_x[25:12], moved_y[39:26]
  output logic        out_tuser,  // zero_chord
  output logic        out_tlast,  // end_of_polygon
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cno_pkg::*;

  cmd_t                     cmd;
  status_t                  sts;
  logic signed [DIST_W-1:0] offset_dist;
  logic [IDX_W-1:0]         o_idx;
  logic [OUT_W-1:0]         o_mx, o_my;

  cno_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .offset_dist
  );

  cno_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .sts, .cmd
  );

  cno_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .vx(in_tdata[11:0]), .vy(in_tdata[23:12]), .vlast(in_tlast), .offset_dist,
    .out_ready(out_tready), .out_valid(out_tvalid),
    .out_idx(o_idx), .out_mx(o_mx), .out_my(o_my),
    .out_zero(out_tuser), .out_eop(out_tlast)
  );

  assign out_tdata = {o_my, o_mx, o_idx};

endmodule

// ===== rtl/cno_checker.sv =====
// Port-level checker for contour_normal_offset_core, bound to the top level.
// Depends on the top level's ports only.
module cno_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // end of polygon is only ever vertex zero
  a_eop_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[11:0] == 12'd0)
    else $error("end of polygon on nonzero index");

  // a closing vertex always starts work, so the input stalls next
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input ready right after closing vertex");

endmodule

bind contour_normal_offset_core cno_checker u_cno_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast,
  .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
